/* src/tkdp_pkg.sv */
// Shared types and constants for the top-k distinct peak tracker.
// Used by tkdp_cell and top_k_distinct_peaks; depends on nothing else.
`default_nettype none

package tkdp_pkg;

  localparam int MAX_PEAKS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam int RANK_W = 4;

  // Per-cycle commands broadcast to every cell of the list.
  typedef struct packed {
    logic call;   // a peak was detected and is offered to the list
    logic trunc;  // drop entries at or beyond the capacity
    logic shift;  // move every entry one place toward the head
  } tkdp_ctrl_t;

endpackage

`default_nettype wire

/* src/tkdp_cell.sv */
// One slot of the sorted peak list: holds a value and its valid flag.
// Depends on tkdp_pkg; instantiated in a chain by top_k_distinct_peaks.
`default_nettype none

module tkdp_cell
  import tkdp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire tkdp_ctrl_t               ctrl,
  input  wire                           cap_ok,
  input  wire                           any_eq,
  input  wire logic signed [SAMPLE_BITS-1:0] new_val,
  input  wire logic signed [SAMPLE_BITS-1:0] prev_val,
  input  wire                           prev_gt,
  input  wire                           prev_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] next_val,
  input  wire                           next_valid,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic                          valid,
  output logic                          gt,
  output logic                          eq
);

  logic                          stored;
  logic                          stored_next;
  logic signed [SAMPLE_BITS-1:0] val_next;
  logic                          wr;

  assign valid = stored & cap_ok;
  assign eq    = valid & (new_val == val);
  assign gt    = ~valid | (new_val > val);
  assign wr    = ctrl.call & ~any_eq & gt & cap_ok;

  always_comb begin
    val_next    = val;
    stored_next = stored;
    if (wr) begin
      val_next    = prev_gt ? prev_val : new_val;
      stored_next = prev_gt ? prev_valid : 1'b1;
    end else if (ctrl.trunc) begin
      stored_next = valid;
    end else if (ctrl.shift) begin
      val_next    = next_val;
      stored_next = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= 1'b0;
    end else begin
      stored <= stored_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

/* src/top_k_distinct_peaks.sv */
// Top level of the top-k distinct peak tracker.
// Depends on tkdp_pkg and tkdp_cell.
//
// Samples arrive on the s_ channel, one request per accepted beat; s_tlast
// marks the final sample of a stream. A three-sample window finds strict
// local maxima, and each peak is offered to a chain of MAX_PEAKS cells that
// keeps distinct values sorted largest first. The compare and shift across
// the chain are combinational and take effect as each sample is accepted.
// After a sample with s_tlast set, the block stops accepting and drains the
// chain to the m_ channel, one result per cycle while m_tready is high,
// head first, as the cells shift toward the head. A stream of n kept peaks
// drains as n results, or as a lone closing result for an empty list; a
// low m_tready holds the drain. The output register holds a result
// until it is taken, so a stall on m_ delays the drain but loses nothing.
// Reset empties the list and window and sets the capacity to sixteen.
// The capacity register may be written only while the block is idle.
`default_nettype none

module top_k_distinct_peaks
  import tkdp_pkg::*;
#(
  parameter int MAX_PEAKS   = MAX_PEAKS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  wire [CAP_W-1:0]         cfg_wdata,    // capacity_in_use
  input  wire                     s_tvalid,
  output logic                    s_tready,
  input  wire [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // sample
  input  wire                     s_tlast,      // end_of_stream
  output logic                    m_tvalid,
  input  wire                     m_tready,
  output logic [((SAMPLE_BITS+RANK_W+7)/8)*8-1:0] m_tdata, // peak_value, rank
  output logic                    m_tuser,      // entry_valid
  output logic                    m_tlast       // last
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  localparam int M_W = ((SAMPLE_BITS + RANK_W + 7) / 8) * 8;

  logic [CAP_W-1:0] cap;
  logic             state;
  logic [RANK_W-1:0] rank;

  logic signed [SAMPLE_BITS-1:0] older;
  logic signed [SAMPLE_BITS-1:0] middle;
  logic [1:0]                    seen;
  logic signed [SAMPLE_BITS-1:0] smp;

  logic       acc;
  logic       eos;
  logic       peak;
  logic       load;
  logic       ld_last;
  tkdp_ctrl_t ctrl;

  logic signed [SAMPLE_BITS-1:0] vals [MAX_PEAKS+1];
  logic [MAX_PEAKS:0]            ev;
  logic [MAX_PEAKS-1:0]          gtv;
  logic [MAX_PEAKS-1:0]          eqv;
  logic [MAX_PEAKS-1:0]          cap_ok;
  logic                          any_eq;
  logic [M_W-1:0]                tdata_next;

  assign smp      = s_tdata[SAMPLE_BITS-1:0];
  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid & s_tready;
  assign eos      = acc & s_tlast;
  assign peak     = acc & (seen == 2'd2) & (middle > smp) & (middle > older);
  assign any_eq   = |eqv;

  assign load    = (state == ST_DRAIN) & (~m_tvalid | m_tready);
  assign ld_last = ~ev[0] | ~ev[1];

  assign ctrl.call  = peak;
  assign ctrl.trunc = peak | eos;
  assign ctrl.shift = load;

  assign vals[MAX_PEAKS] = '0;
  assign ev[MAX_PEAKS]   = 1'b0;

  genvar i;
  generate
    for (i = 0; i < MAX_PEAKS; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] pv;
      logic                          pg;
      logic                          pval;

      assign cap_ok[i] = ({27'd0, cap} > 32'(i));

      if (i == 0) begin : g_head
        assign pv   = '0;
        assign pg   = 1'b0;
        assign pval = 1'b1;
      end else begin : g_body
        assign pv   = vals[i-1];
        assign pg   = gtv[i-1];
        assign pval = ev[i-1];
      end

      tkdp_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .cap_ok    (cap_ok[i]),
        .any_eq    (any_eq),
        .new_val   (middle),
        .prev_val  (pv),
        .prev_gt   (pg),
        .prev_valid(pval),
        .next_val  (vals[i+1]),
        .next_valid(ev[i+1]),
        .val       (vals[i]),
        .valid     (ev[i]),
        .gt        (gtv[i]),
        .eq        (eqv[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= 2'd0;
      older  <= '0;
      middle <= '0;
    end else if (acc) begin
      if (eos) begin
        seen   <= 2'd0;
        older  <= '0;
        middle <= '0;
      end else if (seen == 2'd0) begin
        older <= smp;
        seen  <= 2'd1;
      end else if (seen == 2'd1) begin
        middle <= smp;
        seen   <= 2'd2;
      end else begin
        older  <= middle;
        middle <= smp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rank  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          rank <= '0;
          if (eos) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (load) begin
            rank <= rank + 1'b1;
            if (ld_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    tdata_next                            = '0;
    tdata_next[SAMPLE_BITS-1:0]           = ev[0] ? vals[0] : '0;
    tdata_next[SAMPLE_BITS +: RANK_W]     = rank;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= tdata_next;
      m_tuser <= ev[0];
      m_tlast <= ld_last;
    end
  end

  // The kept entries start at the head: a second entry implies a first.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ev[1] |-> ev[0])
    else $error("peak list has a hole at the head");

  // The head pair is strictly descending.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (ev[0] && ev[1]) |-> (vals[0] > vals[1]))
    else $error("peak list out of order");

  // The final load of a drain returns the block to accepting samples.
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (load && ld_last) |=> s_tready)
    else $error("drain did not finish after last result");

  // A closing result for an empty list always ends the run.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("empty-list result without last");

endmodule

`default_nettype wire
